// File: rtl/core/fve_pkg.sv
package fve_pkg;

    localparam int FADE_SLOTS = 16;
    localparam int IDX_W      = (FADE_SLOTS > 1) ? $clog2(FADE_SLOTS) : 1;
    localparam int FPS_W      = 20;
    localparam int DVD_W      = 48;
    localparam int TOTAL_W    = 32;

    localparam logic [FPS_W-1:0] FPS_RESET = 20'd192000;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_RAMP  = 2'd1;
    localparam logic [1:0] KIND_FINAL = 2'd2;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_NO_SLOT = 1'b1;

    typedef struct packed {
        logic [4:0]         trk;
        logic [7:0]         chn;
        logic [15:0]        from;
        logic signed [16:0] diff;
        logic [TOTAL_W-1:0] total;
        logic signed [32:0] left;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [4:0]  trk;
        logic [7:0]  chn;
        logic [15:0] vol;
        logic        smute;
        logic        cmute;
    } res_t;

endpackage

// File: rtl/core/channel_volume_fade_engine_core.sv
// Channel   Direction  Handshake          Carries
// s_*       in         s_valid / s_ready  one start or tick item
// m_*       out        m_valid / m_ready  one result beat, m_last on the final one
// cfg_*     in         cfg_wr_en          frames_per_second, written at once
//
// A start item reads and checks slots (S_READ, S_CHECK) until a busy slot of the same
// track and channel or the last slot, then loads the picked slot (S_LOAD) and delivers.
// A tick checks every slot; a moving slot runs the one-bit-a-cycle divider (S_DIV).
// Synchronous active-low reset frees all slots. A stalled output holds the walk.
module channel_volume_fade_engine_core import fve_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [FPS_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_opcode,
    input  logic [4:0]       s_track,
    input  logic [7:0]       s_track_channel,
    input  logic [15:0]      s_current_volume,
    input  logic [15:0]      s_target_volume,
    input  logic [15:0]      s_duration_q8,
    input  logic [15:0]      s_frames_elapsed,
    input  logic [31:0]      s_track_loaded_mask,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_kind,
    output logic             m_status,
    output logic [4:0]       m_out_track,
    output logic [7:0]       m_out_channel,
    output logic [15:0]      m_volume,
    output logic             m_set_mute,
    output logic             m_clear_mute,
    output logic             m_last
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_READ  = 8'b00000010,
        S_CHECK = 8'b00000100,
        S_LOAD  = 8'b00001000,
        S_MUL   = 8'b00010000,
        S_DIV   = 8'b00100000,
        S_PUSH  = 8'b01000000,
        S_FLUSH = 8'b10000000
    } state_t;

    state_t                state_reg, state_next;
    logic [FPS_W-1:0]      fps_reg, fps_next;
    logic [FADE_SLOTS-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic                  found_reg, found_next;
    logic                  pend_valid_reg, pend_valid_next;
    res_t                  pend_reg, pend_next;
    res_t                  new_reg, new_next;
    logic                  m_valid_reg, m_valid_next;
    res_t                  out_reg, out_next;
    logic                  out_last_reg, out_last_next;

    logic                  op_reg;
    logic [4:0]            trk_reg;
    logic [7:0]            chn_reg;
    logic [15:0]           cur_reg, tgt_reg, dur_reg, elapsed_reg;
    logic [31:0]           mask_reg;
    entry_t                ent_reg, ent_next;
    logic [TOTAL_W-1:0]    done_reg, done_next;
    logic [15:0]           dmag_reg, dmag_next;
    logic                  neg_reg, neg_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    entry_t                ram_wdata, ram_rdata;
    logic                  div_start, div_done;
    logic [DVD_W-1:0]      div_q;
    logic [35:0]           tot_prod;
    logic [15:0]           qv;
    logic                  out_free, at_end, accept;
    res_t                  r;

    fve_ram #(.WIDTH(ENTRY_W), .DEPTH(FADE_SLOTS)) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    fve_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (DVD_W'(done_reg) * DVD_W'(dmag_reg)),
        .divisor  (ent_reg.total),
        .done     (div_done),
        .quotient (div_q)
    );

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign at_end   = (idx_reg == IDX_W'(FADE_SLOTS - 1));
    assign tot_prod = 36'(fps_reg) * 36'(dur_reg);
    assign qv       = neg_reg ? 16'(-div_q[15:0]) : div_q[15:0];

    always_comb begin
        state_next      = state_reg;
        fps_next        = cfg_wr_en ? cfg_wr_data : fps_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        pick_next       = pick_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        new_next        = new_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        ent_next        = ent_reg;
        done_next       = done_reg;
        dmag_next       = dmag_reg;
        neg_next        = neg_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ent_reg;
        div_start       = 1'b0;
        r               = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (op_reg == OP_START) begin
                    if (!valid_reg[idx_reg]) begin
                        pick_next  = idx_reg;
                        found_next = 1'b1;
                    end else if (ram_rdata.trk == trk_reg && ram_rdata.chn == chn_reg) begin
                        pick_next  = idx_reg;
                        found_next = 1'b1;
                    end
                    if ((valid_reg[idx_reg] && ram_rdata.trk == trk_reg &&
                         ram_rdata.chn == chn_reg) || at_end) begin
                        state_next = S_LOAD;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end else begin
                    r.trk = ram_rdata.trk;
                    r.chn = ram_rdata.chn;
                    if (valid_reg[idx_reg] && mask_reg[ram_rdata.trk] &&
                        !ram_rdata.left[32] && ram_rdata.left != '0) begin
                        ent_next   = ram_rdata;
                        done_next  = ram_rdata.total - ram_rdata.left[TOTAL_W-1:0];
                        neg_next   = ram_rdata.diff[16];
                        dmag_next  = ram_rdata.diff[16] ? 16'(-ram_rdata.diff)
                                                        : ram_rdata.diff[15:0];
                        state_next = S_MUL;
                    end else if (valid_reg[idx_reg] && mask_reg[ram_rdata.trk]) begin
                        r.kind  = KIND_FINAL;
                        r.vol   = 16'(ram_rdata.from + ram_rdata.diff[15:0]);
                        r.smute = (r.vol == '0);
                        new_next   = r;
                        valid_next[idx_reg] = 1'b0;
                        state_next = S_PUSH;
                    end else begin
                        valid_next[idx_reg] = 1'b0;
                        if (at_end) begin
                            state_next = S_FLUSH;
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_LOAD: begin
                r.kind = KIND_ACK;
                r.trk  = trk_reg;
                r.chn  = chn_reg;
                if (found_reg) begin
                    ram_we          = 1'b1;
                    ram_waddr       = pick_reg;
                    ram_wdata.trk   = trk_reg;
                    ram_wdata.chn   = chn_reg;
                    ram_wdata.from  = cur_reg;
                    ram_wdata.diff  = 17'({1'b0, tgt_reg} - {1'b0, cur_reg});
                    ram_wdata.total = TOTAL_W'(tot_prod[35:8]);
                    ram_wdata.left  = 33'(tot_prod[35:8]);
                    valid_next[pick_reg] = 1'b1;
                    r.status = ST_OK;
                    r.cmute  = 1'b1;
                end else begin
                    r.status = ST_NO_SLOT;
                end
                pend_next       = r;
                pend_valid_next = 1'b1;
                state_next      = S_FLUSH;
            end
            S_MUL: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    r.kind   = KIND_RAMP;
                    r.trk    = ent_reg.trk;
                    r.chn    = ent_reg.chn;
                    r.vol    = 16'(ent_reg.from + qv);
                    new_next = r;
                    ram_we   = 1'b1;
                    ram_wdata.left = ent_reg.left - {17'd0, elapsed_reg};
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_next      = pend_reg;
                        out_last_next = 1'b0;
                        m_valid_next  = 1'b1;
                    end
                    pend_next       = new_reg;
                    pend_valid_next = 1'b1;
                    if (at_end) begin
                        state_next = S_FLUSH;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    m_valid_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            fps_reg        <= FPS_RESET;
            valid_reg      <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fps_reg        <= fps_next;
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pick_reg     <= pick_next;
        pend_reg     <= pend_next;
        new_reg      <= new_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        ent_reg      <= ent_next;
        done_reg     <= done_next;
        dmag_reg     <= dmag_next;
        neg_reg      <= neg_next;
        if (accept) begin
            op_reg      <= s_opcode;
            trk_reg     <= s_track;
            chn_reg     <= s_track_channel;
            cur_reg     <= s_current_volume;
            tgt_reg     <= s_target_volume;
            dur_reg     <= s_duration_q8;
            elapsed_reg <= s_frames_elapsed;
            mask_reg    <= s_track_loaded_mask;
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_kind        = out_reg.kind;
    assign m_status      = out_reg.status;
    assign m_out_track   = out_reg.trk;
    assign m_out_channel = out_reg.chn;
    assign m_volume      = out_reg.vol;
    assign m_set_mute    = out_reg.smute;
    assign m_clear_mute  = out_reg.cmute;
    assign m_last        = out_last_reg;

`ifndef NO_ASSERTIONS
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending result left over in idle");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide wait");

    a_ram_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_LOAD || state_reg == S_DIV))
        else $error("slot write from an unexpected state");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_READ)
        else $error("accepted item did not start the slot walk");
`endif

endmodule

// File: rtl/core/fve_ram.sv
module fve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/core/fve_div.sv
module fve_div import fve_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DVD_W-1:0]   dividend,
    input  logic [TOTAL_W-1:0] divisor,
    output logic               done,
    output logic [DVD_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [TOTAL_W-1:0] rem_reg, rem_next;
    logic [TOTAL_W-1:0] dvs_reg, dvs_next;
    logic [DVD_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [TOTAL_W:0]   trial;

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        if (start) begin
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = TOTAL_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[TOTAL_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: dv/tb_channel_volume_fade_engine_core.sv
module tb_channel_volume_fade_engine_core;
    import fve_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     SETTLE      = 1200;

    typedef struct packed {
        logic        op;
        logic [4:0]  trk;
        logic [7:0]  chn;
        logic [15:0] cur;
        logic [15:0] tgt;
        logic [15:0] dur;
        logic [15:0] elapsed;
        logic [31:0] mask;
    } fade_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [4:0]  trk;
        logic [7:0]  chn;
        logic [15:0] vol;
        logic        smute;
        logic        cmute;
        logic        last;
    } fade_beat_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [FPS_W-1:0] cfg_wr_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    fade_cmd_t        drv = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    fade_beat_t       got;

    channel_volume_fade_engine_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(drv.op), .s_track(drv.trk), .s_track_channel(drv.chn),
        .s_current_volume(drv.cur), .s_target_volume(drv.tgt),
        .s_duration_q8(drv.dur), .s_frames_elapsed(drv.elapsed),
        .s_track_loaded_mask(drv.mask),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(got.kind), .m_status(got.status), .m_out_track(got.trk),
        .m_out_channel(got.chn), .m_volume(got.vol), .m_set_mute(got.smute),
        .m_clear_mute(got.cmute), .m_last(got.last)
    );

    fade_cmd_t  pending_cmds[$];
    fade_beat_t expected_beats[$];

    logic [FPS_W-1:0] fps_now = FPS_RESET;
    logic             slot_busy[FADE_SLOTS];
    logic [12:0]      slot_key[FADE_SLOTS];
    logic [15:0]      slot_from[FADE_SLOTS];
    longint           slot_diff[FADE_SLOTS];
    longint           slot_total[FADE_SLOTS];
    longint           slot_left[FADE_SLOTS];

    int     send_idle_pct = 26;
    int     recv_idle_pct = 55;
    int     errors = 0;
    int     beats_seen = 0;
    int     cmds_taken = 0;
    int     no_slot_seen = 0;
    int     finals_seen = 0;
    longint cycles = 0;
    int     stall_left = 0;
    logic   stall_go = 1'b0;
    logic   stall_done = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic fade_beat_t mk_beat(logic [1:0] kind, logic status, logic [4:0] trk,
                                           logic [7:0] chn, logic [15:0] vol,
                                           logic smute, logic cmute);
        fade_beat_t b;
        b = '{kind, status, trk, chn, vol, smute, cmute, 1'b0};
        return b;
    endfunction

    task automatic fade_predict(input fade_cmd_t c);
        fade_beat_t outs[$];
        fade_beat_t b;
        logic [12:0] key;
        int     pick;
        longint q;
        longint v;
        pick = -1;
        key = {c.trk, c.chn};
        if (c.op == OP_START) begin
            for (int i = 0; i < FADE_SLOTS; i++) begin
                if (!slot_busy[i]) begin
                    pick = i;
                end else if (slot_key[i] == key) begin
                    pick = i;
                    break;
                end
            end
            if (pick < 0) begin
                outs.push_back(mk_beat(KIND_ACK, ST_NO_SLOT, c.trk, c.chn, 16'd0, 1'b0, 1'b0));
            end else begin
                slot_busy[pick] = 1'b1;
                slot_key[pick] = key;
                slot_from[pick] = c.cur;
                slot_diff[pick] = longint'(c.tgt) - longint'(c.cur);
                slot_total[pick] = (longint'(fps_now) * longint'(c.dur)) >>> 8;
                slot_left[pick] = slot_total[pick];
                outs.push_back(mk_beat(KIND_ACK, ST_OK, c.trk, c.chn, 16'd0, 1'b0, 1'b1));
            end
        end else begin
            for (int i = 0; i < FADE_SLOTS; i++) begin
                if (!slot_busy[i]) continue;
                if (!c.mask[slot_key[i][12:8]]) begin
                    slot_busy[i] = 1'b0;
                end else if (slot_left[i] > 0) begin
                    q = 0;
                    if (slot_total[i] != 0)
                        q = ((slot_total[i] - slot_left[i]) * slot_diff[i]) / slot_total[i];
                    v = longint'(slot_from[i]) + q;
                    outs.push_back(mk_beat(KIND_RAMP, ST_OK, slot_key[i][12:8],
                                           slot_key[i][7:0], v[15:0], 1'b0, 1'b0));
                    slot_left[i] = slot_left[i] - longint'(c.elapsed);
                end else begin
                    v = longint'(slot_from[i]) + slot_diff[i];
                    outs.push_back(mk_beat(KIND_FINAL, ST_OK, slot_key[i][12:8],
                                           slot_key[i][7:0], v[15:0], v[15:0] == 16'd0,
                                           1'b0));
                    slot_busy[i] = 1'b0;
                end
            end
        end
        if (outs.size() > 0)
            outs[outs.size()-1].last = 1'b1;
        foreach (outs[k]) expected_beats.push_back(outs[k]);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                fade_predict(drv);
                cmds_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv <= pending_cmds.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (stall_go && !stall_done) begin
            stall_left <= 4000;
            stall_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        fade_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual %p", $time, got);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                if (got.kind == KIND_FINAL) finals_seen++;
                if (got.status == ST_NO_SLOT) no_slot_seen++;
                if (got.kind !== want.kind || got.status !== want.status ||
                    got.trk !== want.trk || got.chn !== want.chn ||
                    got.vol !== want.vol || got.smute !== want.smute ||
                    got.cmute !== want.cmute || got.last !== want.last) begin
                    $display("%0t beat mismatch: expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
        m_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic drain();
        while (pending_cmds.size() != 0 || s_valid || expected_beats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_fps(input logic [FPS_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        fps_now = v;
    endtask

    function automatic fade_cmd_t start_cmd(logic [4:0] trk, logic [7:0] chn, logic [15:0] cur,
                                            logic [15:0] tgt, logic [15:0] dur);
        fade_cmd_t c;
        c = '{OP_START, trk, chn, cur, tgt, dur, 16'($urandom()), $urandom()};
        return c;
    endfunction

    function automatic fade_cmd_t tick_cmd(logic [15:0] elapsed, logic [31:0] mask);
        fade_cmd_t c;
        c = '{OP_TICK, 5'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()), elapsed, mask};
        return c;
    endfunction

    function automatic fade_cmd_t random_cmd();
        logic [15:0] dur;
        logic [15:0] el;
        logic [31:0] mask;
        logic [4:0]  trk;
        logic [7:0]  chn;
        int r;
        r = $urandom_range(99);
        if ($urandom_range(3) == 0) begin
            trk = 5'($urandom());
            chn = 8'($urandom());
        end else begin
            trk = 5'($urandom_range(3));
            chn = 8'($urandom_range(5));
        end
        if (r < 45) begin
            case ($urandom_range(9))
                0: dur = 16'($urandom());
                1: dur = 16'hFFFF;
                2: dur = 16'd0;
                default: dur = 16'($urandom_range(12));
            endcase
            return start_cmd(trk, chn, 16'($urandom()), 16'($urandom()), dur);
        end
        case ($urandom_range(9))
            0: el = 16'hFFFF;
            1: el = 16'd0;
            2: el = 16'($urandom());
            default: el = 16'($urandom_range(6000));
        endcase
        case ($urandom_range(9))
            0: mask = $urandom();
            1: mask = 32'd0;
            2: mask = ~(32'd1 << $urandom_range(31));
            default: mask = 32'hFFFF_FFFF;
        endcase
        return tick_cmd(el, mask);
    endfunction

    initial begin
        for (int i = 0; i < FADE_SLOTS; i++) slot_busy[i] = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        pending_cmds.push_back(start_cmd(5'd0, 8'd0, 16'd0, 16'hFFFF, 16'd1));
        pending_cmds.push_back(start_cmd(5'd31, 8'd255, 16'hFFFF, 16'd0, 16'd0));
        pending_cmds.push_back(start_cmd(5'd0, 8'd0, 16'hFFFF, 16'd0, 16'hFFFF));
        pending_cmds.push_back(tick_cmd(16'd0, 32'hFFFF_FFFF));
        pending_cmds.push_back(tick_cmd(16'hFFFF, 32'hFFFF_FFFF));
        pending_cmds.push_back(tick_cmd(16'd100, 32'hFFFF_FFFF));
        for (int i = 0; i < 17; i++)
            pending_cmds.push_back(start_cmd(i[4:0] + 5'd2, 8'hA5 ^ i[7:0],
                                             16'($urandom()), 16'($urandom()), 16'd2));
        pending_cmds.push_back(tick_cmd(16'd0, 32'hFFFF_FFFF));
        pending_cmds.push_back(tick_cmd(16'd0, 32'd0));
        drain();

        write_fps('0);
        pending_cmds.push_back(start_cmd(5'd7, 8'd9, 16'd300, 16'd0, 16'd40));
        pending_cmds.push_back(start_cmd(5'd7, 8'd10, 16'd300, 16'd0, 16'd0));
        pending_cmds.push_back(tick_cmd(16'd5, 32'hFFFF_FFFF));
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 26;
                    recv_idle_pct = 55;
                    write_fps(20'hFFFFF);
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 26;
                    write_fps(20'd1);
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_fps(20'($urandom_range(20'hFFFFF, 1)));
                end
            endcase
            if (phase == 0) begin
                for (int i = 0; i < 16; i++)
                    pending_cmds.push_back(start_cmd(i[4:0], 8'd1, 16'($urandom()),
                                                     16'($urandom()), 16'd3));
                for (int i = 0; i < 12; i++)
                    pending_cmds.push_back(tick_cmd(16'd2000, 32'hFFFF_FFFF));
                stall_go = 1'b1;
            end
            for (int i = 0; i < 101; i++)
                pending_cmds.push_back(random_cmd());
            drain();
        end

        $display("Accepted %0d items and checked %0d result beats across three idle settings.",
                 cmds_taken, beats_seen);
        $display("Seen %0d final-volume beats and %0d no-slot rejections.",
                 finals_seen, no_slot_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/fve_pkg.sv
rtl/core/fve_ram.sv
rtl/core/fve_div.sv
rtl/core/channel_volume_fade_engine_core.sv
dv/tb_channel_volume_fade_engine_core.sv
